FILE: rtl/extent_overlay_map_top_assert.svh
// assertion macros for the extent overlay map
// no dependencies; included by modules that carry concurrent checks
`ifndef EXTENT_OVERLAY_MAP_TOP_ASSERT_SVH
`define EXTENT_OVERLAY_MAP_TOP_ASSERT_SVH

// same-cycle implication, sampled on clk, off during reset
`define EOM_CHECK(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// next-cycle implication, sampled on clk, off during reset
`define EOM_CHECK_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

FILE: rtl/eom_pkg.sv
// shared types and constants for the extent overlay map
// used by eom_ctrl, eom_dp and extent_overlay_map_top
package eom_pkg;

	// record length field width
	localparam int LEN_BITS = 32;

	// commands from controller to datapath
	typedef struct packed {
		logic       accept;
		logic       init;
		logic       rd;
		logic       calc;
		logic       look;
		logic       emit;
		logic [1:0] slot;
		logic       next;
		logic       emit_new;
		logic       commit;
		logic       res_load;
	} eom_cmd_t;

	// status from datapath to controller
	typedef struct packed {
		logic       lookup;
		logic       at_end;
		logic       look_done;
		logic       pre_phase;
		logic [1:0] emit_cnt;
	} eom_sts_t;

endpackage

FILE: rtl/eom_ctrl.sv
// sequencer for the extent overlay map: item intake, table scan, result hand-off
// depends on eom_pkg
module eom_ctrl import eom_pkg::*; (
	input  logic     clk,
	input  logic     arst_n,
	input  logic     in_valid,
	output logic     in_stall,
	output logic     out_valid,
	input  logic     out_stall,
	input  eom_sts_t sts,
	output eom_cmd_t cmd
);

	localparam logic [2:0] S_IDLE   = 3'd0;
	localparam logic [2:0] S_PREP   = 3'd1;
	localparam logic [2:0] S_RD     = 3'd2;
	localparam logic [2:0] S_LD     = 3'd3;
	localparam logic [2:0] S_EM     = 3'd4;
	localparam logic [2:0] S_FIN    = 3'd5;
	localparam logic [2:0] S_COMMIT = 3'd6;
	localparam logic [2:0] S_DONE   = 3'd7;

	logic [2:0] state_q, state_d;
	logic [1:0] slot_q, slot_d;
	logic       out_valid_q;

	// next state and commands
	always_comb begin
		cmd     = '0;
		state_d = state_q;
		slot_d  = slot_q;
		unique case (state_q)
			S_IDLE: begin
				if (in_valid) begin
					cmd.accept = 1'b1;
					state_d    = S_PREP;
				end
			end
			S_PREP: begin
				cmd.init = 1'b1;
				slot_d   = 2'd0;
				state_d  = S_RD;
			end
			S_RD: begin
				if (sts.at_end) begin
					state_d = S_FIN;
				end else begin
					cmd.rd  = 1'b1;
					state_d = S_LD;
				end
			end
			S_LD: begin
				cmd.calc = 1'b1;
				state_d  = S_EM;
			end
			S_EM: begin
				if (sts.lookup) begin
					cmd.look = 1'b1;
					if (sts.look_done) begin
						state_d = S_DONE;
					end else begin
						cmd.next = 1'b1;
						state_d  = S_RD;
					end
				end else if (slot_q < sts.emit_cnt) begin
					cmd.emit = 1'b1;
					cmd.slot = slot_q;
					slot_d   = slot_q + 2'd1;
				end else begin
					cmd.next = 1'b1;
					slot_d   = 2'd0;
					state_d  = S_RD;
				end
			end
			S_FIN: begin
				if (sts.lookup) begin
					state_d = S_DONE;
				end else begin
					cmd.emit_new = sts.pre_phase;
					state_d      = S_COMMIT;
				end
			end
			S_COMMIT: begin
				cmd.commit = 1'b1;
				state_d    = S_DONE;
			end
			S_DONE: begin
				if (!out_valid_q || !out_stall) begin
					cmd.res_load = 1'b1;
					state_d      = S_IDLE;
				end
			end
		endcase
	end

	// state registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			slot_q      <= 2'd0;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			slot_q  <= slot_d;
			if (cmd.res_load) begin
				out_valid_q <= 1'b1;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	assign in_stall  = (state_q != S_IDLE);
	assign out_valid = out_valid_q;

endmodule

FILE: rtl/eom_dp.sv
// datapath of the extent overlay map: double-banked extent memory, merge stream, lookup
// depends on eom_pkg and extent_overlay_map_top_assert.svh
`include "extent_overlay_map_top_assert.svh"

module eom_dp import eom_pkg::*; #(
	parameter int EXTENT_DEPTH = 64,
	parameter int OFFSET_BITS  = 48,
	parameter int SOURCE_BITS  = 16
) (
	input  logic                   clk,
	input  logic                   arst_n,
	input  eom_cmd_t               cmd,
	output eom_sts_t               sts,
	input  logic                   mode,
	input  logic [OFFSET_BITS-1:0] logical_offset,
	input  logic [LEN_BITS-1:0]    record_length,
	input  logic [OFFSET_BITS-1:0] src_offset,
	input  logic [SOURCE_BITS-1:0] source_id,
	input  logic                   source_valid,
	output logic [SOURCE_BITS-1:0] hit_source,
	output logic [OFFSET_BITS-1:0] hit_physical,
	output logic [OFFSET_BITS-1:0] run_length,
	output logic                   is_hole,
	output logic [OFFSET_BITS-1:0] file_size,
	output logic                   table_overflow
);

	localparam int IDXW = (EXTENT_DEPTH > 1) ? $clog2(EXTENT_DEPTH) : 1;
	localparam int CNTW = $clog2(EXTENT_DEPTH + 3);
	localparam int AW   = IDXW + 1;
	localparam int ENTW = 2 * OFFSET_BITS + LEN_BITS + SOURCE_BITS;
	localparam int SUMW = ((OFFSET_BITS > LEN_BITS) ? OFFSET_BITS : LEN_BITS) + 1;
	localparam logic [OFFSET_BITS-1:0] OMAX = '1;
	localparam logic [SOURCE_BITS-1:0] SMAX = '1;

	// kinds of entry written to the new bank
	localparam logic [1:0] K_OLD  = 2'd0;
	localparam logic [1:0] K_TRIM = 2'd1;
	localparam logic [1:0] K_NEW  = 2'd2;
	localparam logic [1:0] K_TAIL = 2'd3;

	// merge stream phases
	localparam logic [1:0] PH_PRE  = 2'd0;
	localparam logic [1:0] PH_POST = 2'd1;
	localparam logic [1:0] PH_DROP = 2'd2;

	// end of an extent, saturating at the top of the offset range
	function automatic logic [OFFSET_BITS-1:0] sat_end(input logic [OFFSET_BITS-1:0] s,
			input logic [LEN_BITS-1:0] l);
		logic [SUMW-1:0] sum;
		sum = SUMW'(s) + SUMW'(l);
		if (sum > SUMW'(OMAX)) begin
			sat_end = OMAX;
		end else begin
			sat_end = sum[OFFSET_BITS-1:0];
		end
	endfunction

	// item registers
	logic                   mode_q;
	logic [OFFSET_BITS-1:0] off_q;
	logic [LEN_BITS-1:0]    len_q;
	logic [OFFSET_BITS-1:0] iphys_q;
	logic [SOURCE_BITS-1:0] isrc_q;
	logic [OFFSET_BITS-1:0] e_q;
	logic                   trunc_q;
	logic                   eeo_q;
	logic [OFFSET_BITS-1:0] e_nx;

	// table state
	logic                   bank_q;
	logic [CNTW-1:0]        count_q;
	logic [OFFSET_BITS-1:0] fsize_q;
	logic [CNTW-1:0]        idx_q;
	logic [CNTW-1:0]        wcnt_q;
	logic [1:0]             phase_q;
	logic [OFFSET_BITS-1:0] lastend_q;
	logic                   ovf_q;
	logic                   fits;

	// lookup state
	logic                   hit_q;
	logic                   gap_q;
	logic [SOURCE_BITS-1:0] hsrc_q;
	logic [OFFSET_BITS-1:0] hphys_q;
	logic [OFFSET_BITS-1:0] hrun_q;
	logic [OFFSET_BITS-1:0] gstart_q;

	// memory and read pipeline
	logic [ENTW-1:0]        mem [0:2*EXTENT_DEPTH-1];
	logic [ENTW-1:0]        rd_s1;
	logic [AW-1:0]          rd_addr;
	logic [AW-1:0]          wr_addr;
	logic                   wr_en;
	logic                   emit_any;
	logic [ENTW-1:0]        wr_data;
	logic [OFFSET_BITS-1:0] s1_start;
	logic [LEN_BITS-1:0]    s1_len;
	logic [OFFSET_BITS-1:0] s1_phys;
	logic [SOURCE_BITS-1:0] s1_src;
	logic [OFFSET_BITS-1:0] en_s2;
	logic [OFFSET_BITS-1:0] de_s2;
	logic [OFFSET_BITS-1:0] dof_s2;

	// decision signals
	logic s_lt_off, s_gt_off, s_eq_off, s_lt_e, en_gt_off, en_gt_e, s1_hole;
	logic [1:0]             k0, k1, k2, kind;
	logic [1:0]             ecnt;
	logic [1:0]             ph_nx;
	logic [OFFSET_BITS-1:0] wend;

	assign e_nx = sat_end(off_q, len_q);

	// entry fields
	assign s1_start = rd_s1[ENTW-1 -: OFFSET_BITS];
	assign s1_len   = rd_s1[ENTW-OFFSET_BITS-1 -: LEN_BITS];
	assign s1_phys  = rd_s1[SOURCE_BITS+OFFSET_BITS-1 -: OFFSET_BITS];
	assign s1_src   = rd_s1[SOURCE_BITS-1:0];
	assign s1_hole  = (s1_len == '0) && (s1_phys == OMAX);

	// compares against the item
	assign s_lt_off  = (s1_start < off_q);
	assign s_gt_off  = (off_q < s1_start);
	assign s_eq_off  = (s1_start == off_q);
	assign s_lt_e    = (s1_start < e_q);
	assign en_gt_off = (en_s2 > off_q);
	assign en_gt_e   = (en_s2 > e_q);

	// what the current old entry turns into in the new bank
	always_comb begin
		k0    = K_OLD;
		k1    = K_OLD;
		k2    = K_OLD;
		ecnt  = 2'd0;
		ph_nx = phase_q;
		if (phase_q == PH_POST) begin
			ecnt = 2'd1;
		end else if (phase_q == PH_PRE) begin
			if (s_lt_off) begin
				// entry starts before the record: trim it, maybe split around it
				if (en_gt_off) begin
					k0 = K_TRIM;
					if (!trunc_q && en_gt_e) begin
						k1    = K_NEW;
						k2    = K_TAIL;
						ecnt  = eeo_q ? 2'd2 : 2'd3;
						ph_nx = PH_POST;
					end else begin
						ecnt = 2'd1;
					end
				end else begin
					ecnt = 2'd1;
				end
			end else if (trunc_q) begin
				k0    = K_NEW;
				ecnt  = 2'd1;
				ph_nx = PH_DROP;
			end else if (s_lt_e) begin
				// entry starts inside the record: drop it or keep its tail
				if (en_gt_e) begin
					k0    = K_NEW;
					k1    = K_TAIL;
					ecnt  = 2'd2;
					ph_nx = PH_POST;
				end
			end else begin
				// first entry past the record; same start is replaced
				k0    = K_NEW;
				k1    = K_OLD;
				ecnt  = s_eq_off ? 2'd1 : 2'd2;
				ph_nx = PH_POST;
			end
		end
	end

	// slot selection
	always_comb begin
		if (cmd.emit_new) begin
			kind = K_NEW;
		end else begin
			unique case (cmd.slot)
				2'd0:    kind = k0;
				2'd1:    kind = k1;
				default: kind = k2;
			endcase
		end
	end

	// write data per kind
	always_comb begin
		unique case (kind)
			K_OLD: begin
				wr_data = rd_s1;
				wend    = en_s2;
			end
			K_TRIM: begin
				wr_data = {s1_start, LEN_BITS'(dof_s2), s1_phys, s1_src};
				wend    = off_q;
			end
			K_NEW: begin
				wr_data = {off_q, len_q, iphys_q, isrc_q};
				wend    = e_q;
			end
			K_TAIL: begin
				wr_data = {e_q, LEN_BITS'(en_s2 - e_q), s1_phys + de_s2, s1_src};
				wend    = en_s2;
			end
		endcase
	end

	// bank addressing
	assign rd_addr  = bank_q ? (AW'(EXTENT_DEPTH) + AW'(idx_q[IDXW-1:0]))
	                         : AW'(idx_q[IDXW-1:0]);
	assign wr_addr  = bank_q ? AW'(wcnt_q[IDXW-1:0])
	                         : (AW'(EXTENT_DEPTH) + AW'(wcnt_q[IDXW-1:0]));
	assign emit_any = cmd.emit || cmd.emit_new;
	assign wr_en    = emit_any && (wcnt_q < CNTW'(EXTENT_DEPTH));
	assign fits     = (wcnt_q <= CNTW'(EXTENT_DEPTH));

	// extent memory
	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
		if (cmd.rd) begin
			rd_s1 <= mem[rd_addr];
		end
	end

	// control state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q  <= 1'b0;
			bank_q  <= 1'b0;
			count_q <= '0;
			fsize_q <= '0;
			idx_q   <= '0;
			wcnt_q  <= '0;
			phase_q <= PH_PRE;
			hit_q   <= 1'b0;
			gap_q   <= 1'b0;
			ovf_q   <= 1'b0;
		end else begin
			if (cmd.accept) begin
				mode_q <= mode;
			end
			if (cmd.init) begin
				idx_q   <= '0;
				wcnt_q  <= '0;
				phase_q <= PH_PRE;
				hit_q   <= 1'b0;
				gap_q   <= 1'b0;
			end
			if (emit_any) begin
				wcnt_q <= wcnt_q + CNTW'(1);
			end
			if (cmd.next) begin
				idx_q   <= idx_q + CNTW'(1);
				phase_q <= ph_nx;
			end
			if (cmd.look) begin
				if (!s_gt_off) begin
					hit_q <= en_gt_off;
				end else if (!hit_q) begin
					gap_q <= 1'b1;
				end
			end
			if (cmd.commit) begin
				ovf_q <= !fits;
				if (fits) begin
					bank_q  <= ~bank_q;
					count_q <= wcnt_q;
					fsize_q <= lastend_q;
				end
			end
		end
	end

	// item, pipeline and result payload
	always_ff @(posedge clk) begin
		if (cmd.accept) begin
			off_q   <= logical_offset;
			len_q   <= record_length;
			iphys_q <= src_offset;
			isrc_q  <= source_valid ? source_id : SMAX;
		end
		if (cmd.init) begin
			e_q     <= e_nx;
			eeo_q   <= (e_nx == off_q);
			trunc_q <= (len_q == '0) && (iphys_q == OMAX);
		end
		if (cmd.calc) begin
			en_s2  <= sat_end(s1_start, s1_len);
			de_s2  <= e_q - s1_start;
			dof_s2 <= off_q - s1_start;
		end
		if (emit_any) begin
			lastend_q <= wend;
		end
		if (cmd.look && !s_gt_off) begin
			hsrc_q  <= s1_src;
			hphys_q <= s1_phys + dof_s2;
			hrun_q  <= en_s2 - off_q;
		end
		if (cmd.look && s_gt_off && !hit_q) begin
			gstart_q <= s1_start;
		end
		if (cmd.res_load) begin
			file_size <= fsize_q;
			if (!mode_q) begin
				hit_source     <= '0;
				hit_physical   <= '0;
				run_length     <= '0;
				is_hole        <= 1'b0;
				table_overflow <= ovf_q;
			end else if (hit_q) begin
				hit_source     <= hsrc_q;
				hit_physical   <= hphys_q;
				run_length     <= hrun_q;
				is_hole        <= 1'b0;
				table_overflow <= 1'b0;
			end else begin
				hit_source     <= SMAX;
				hit_physical   <= OMAX;
				run_length     <= gap_q ? (gstart_q - off_q) : '0;
				is_hole        <= 1'b1;
				table_overflow <= 1'b0;
			end
		end
	end

	// status
	assign sts.lookup    = mode_q;
	assign sts.at_end    = (idx_q == count_q);
	assign sts.look_done = s_gt_off && (hit_q || !s1_hole);
	assign sts.pre_phase = (phase_q == PH_PRE);
	assign sts.emit_cnt  = ecnt;

	// checks
	`EOM_CHECK(a_count_bound, 1'b1, count_q <= CNTW'(EXTENT_DEPTH), "extent count beyond depth")
	`EOM_CHECK(a_scan_bound, cmd.rd, idx_q < count_q, "read past end of table")
	`EOM_CHECK_NEXT(a_bank_swap, cmd.commit && fits, bank_q != $past(bank_q), "no bank swap")
	`EOM_CHECK_NEXT(a_ovf_keep, cmd.commit && !fits, $stable(count_q) && ovf_q, "table changed")

endmodule

FILE: rtl/extent_overlay_map_top.sv
// top level of the extent overlay map
// depends on eom_pkg, eom_ctrl and eom_dp

// Sorted table of up to EXTENT_DEPTH non-overlapping extents held in one memory
// of two banks; one item is taken at a time and gives one result. A lookup reads
// the table one entry at a time (read, end add, decide) up to the first extent
// starting past the offset, where a hole marker does not end the scan before a
// hit, or up to the end of the table. A merge streams every stored entry from one
// bank into the other with its trims, removals, splits and the new extent, then
// swaps banks. A result held by out_stall adds its wait, and the next item is
// taken no earlier than the cycle after the result is loaded. A merge that would
// exceed the depth leaves the table as it was and flags overflow. No clearing pass
// after reset; the table starts empty.
module extent_overlay_map_top import eom_pkg::*; #(
	parameter int EXTENT_DEPTH = 64,
	parameter int OFFSET_BITS  = 48,
	parameter int SOURCE_BITS  = 16
) (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   in_valid,
	output logic                   in_stall,
	input  logic                   mode,
	input  logic [OFFSET_BITS-1:0] logical_offset,
	input  logic [LEN_BITS-1:0]    record_length,
	input  logic [OFFSET_BITS-1:0] src_offset,
	input  logic [SOURCE_BITS-1:0] source_id,
	input  logic                   source_valid,
	output logic                   out_valid,
	input  logic                   out_stall,
	output logic [SOURCE_BITS-1:0] hit_source,
	output logic [OFFSET_BITS-1:0] hit_physical,
	output logic [OFFSET_BITS-1:0] run_length,
	output logic                   is_hole,
	output logic [OFFSET_BITS-1:0] file_size,
	output logic                   table_overflow
);

	eom_cmd_t cmd;
	eom_sts_t sts;

	// sequencer
	eom_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_stall  (in_stall),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.sts       (sts),
		.cmd       (cmd)
	);

	// table memory and arithmetic
	eom_dp #(
		.EXTENT_DEPTH (EXTENT_DEPTH),
		.OFFSET_BITS  (OFFSET_BITS),
		.SOURCE_BITS  (SOURCE_BITS)
	) u_dp (
		.clk             (clk),
		.arst_n          (arst_n),
		.cmd             (cmd),
		.sts             (sts),
		.mode            (mode),
		.logical_offset  (logical_offset),
		.record_length   (record_length),
		.src_offset      (src_offset),
		.source_id       (source_id),
		.source_valid    (source_valid),
		.hit_source      (hit_source),
		.hit_physical    (hit_physical),
		.run_length      (run_length),
		.is_hole         (is_hole),
		.file_size       (file_size),
		.table_overflow  (table_overflow)
	);

endmodule

FILE: bench/extent_overlay_map_top_tb.sv
// self-checking testbench for extent_overlay_map_top: directed and random merges,
// truncates and lookups, with a built-in extent table predictor
// depends on eom_pkg and the extent_overlay_map_top rtl
`timescale 1ns / 1ps

module extent_overlay_map_top_tb;
	import eom_pkg::*;

	localparam int DEPTH = 64;
	localparam int WCAP = DEPTH + 2;
	localparam int WDOG_LIMIT = 20000;
	localparam logic [47:0] OFS_ONES = '1;
	localparam logic [15:0] SRC_ONES = '1;
	localparam logic MODE_MERGE = 1'b0;
	localparam logic MODE_LOOKUP = 1'b1;

	typedef struct {
		logic        mode;
		logic [47:0] offset;
		logic [31:0] length;
		logic [47:0] phys;
		logic [15:0] sid;
		logic        sid_ok;
		bit          drain;
	} rec_t;

	typedef struct {
		logic [15:0] src;
		logic [47:0] phys;
		logic [47:0] run;
		logic        hole;
		logic [47:0] size;
		logic        ovf;
	} res_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic in_valid, in_stall, mode, source_valid;
	logic [47:0] logical_offset, src_offset;
	logic [31:0] record_length;
	logic [15:0] source_id;
	logic out_valid, out_stall;
	logic [15:0] hit_source;
	logic [47:0] hit_physical, run_length, file_size;
	logic is_hole, table_overflow;

	rec_t rec_q[$];
	res_t result_q[$];
	int tx_idle_pct = 0;
	int rx_stall_pct = 0;
	int errors = 0;
	int n_merge = 0, n_lookup = 0, n_ovf = 0, n_hole = 0;
	int quiet_cycles = 0;

	// predicted table contents
	bit [47:0] tab_start[DEPTH];
	bit [31:0] tab_len[DEPTH];
	bit [47:0] tab_phys[DEPTH];
	bit [15:0] tab_src[DEPTH];
	int tab_n = 0;

	// scratch table for a merge in progress
	bit [47:0] wk_start[WCAP];
	bit [31:0] wk_len[WCAP];
	bit [47:0] wk_phys[WCAP];
	bit [15:0] wk_src[WCAP];
	int wk_n;

	always #4 clk = ~clk;

	extent_overlay_map_top u_dut (
		.clk(clk), .arst_n(arst_n),
		.in_valid(in_valid), .in_stall(in_stall),
		.mode(mode), .logical_offset(logical_offset), .record_length(record_length),
		.src_offset(src_offset), .source_id(source_id),
		.source_valid(source_valid),
		.out_valid(out_valid), .out_stall(out_stall),
		.hit_source(hit_source), .hit_physical(hit_physical), .run_length(run_length),
		.is_hole(is_hole), .file_size(file_size), .table_overflow(table_overflow)
	);

	// append one item to the pending queue
	function automatic void add_rec(rec_t r);
		rec_q.insert(rec_q.size(), r);
	endfunction

	// extent end, saturating at the top of the offset space
	function automatic bit [47:0] extent_end(bit [47:0] s, bit [47:0] l);
		bit [48:0] sum;
		sum = {1'b0, s} + {1'b0, l};
		return sum[48] ? OFS_ONES : sum[47:0];
	endfunction

	function automatic int wk_lower(bit [47:0] key);
		int i;
		i = 0;
		while (i < wk_n && wk_start[i] < key) i++;
		return i;
	endfunction

	function automatic void wk_erase(int i);
		if (i >= wk_n) return;
		for (int k = i; k + 1 < wk_n; k++) begin
			wk_start[k] = wk_start[k+1];
			wk_len[k] = wk_len[k+1];
			wk_phys[k] = wk_phys[k+1];
			wk_src[k] = wk_src[k+1];
		end
		wk_n--;
	endfunction

	// insert or replace the entry keyed by start
	function automatic void wk_put(bit [47:0] key, bit [15:0] s, bit [47:0] p, bit [47:0] l);
		int i;
		i = wk_lower(key);
		if (!(i < wk_n && wk_start[i] == key)) begin
			if (wk_n >= WCAP) return;
			for (int k = wk_n; k > i; k--) begin
				wk_start[k] = wk_start[k-1];
				wk_len[k] = wk_len[k-1];
				wk_phys[k] = wk_phys[k-1];
				wk_src[k] = wk_src[k-1];
			end
			wk_n++;
			wk_start[i] = key;
		end
		wk_src[i] = s;
		wk_phys[i] = p;
		wk_len[i] = l[31:0];
	endfunction

	// overlay one record on the table; returns 0 when it does not fit
	function automatic bit overlay_record(bit [47:0] off, bit [31:0] len, bit [47:0] phys,
			bit [15:0] s);
		bit [47:0] e, ej, ei, p;
		bit [15:0] sv;
		bit trunc, done;
		int i, j;
		e = extent_end(off, {16'd0, len});
		wk_n = tab_n;
		for (int k = 0; k < tab_n; k++) begin
			wk_start[k] = tab_start[k];
			wk_len[k] = tab_len[k];
			wk_phys[k] = tab_phys[k];
			wk_src[k] = tab_src[k];
		end
		if (wk_n != 0) begin
			trunc = (len == 0 && phys == OFS_ONES);
			done = 0;
			i = wk_lower(off);
			// trim the extent that starts before the record, splitting if needed
			if ((i == wk_n || wk_start[i] != off) && i != 0) begin
				j = i - 1;
				ej = extent_end(wk_start[j], {16'd0, wk_len[j]});
				if (ej > off) begin
					wk_len[j] = 32'(off - wk_start[j]);
					if (!trunc && ej > e) begin
						wk_put(e, wk_src[j], wk_phys[j] + (e - wk_start[j]), ej - e);
						done = 1;
					end
				end
			end
			if (!done && trunc) begin
				wk_n = i;
				done = 1;
			end
			// remove covered extents, keep the tail of a partly covered one
			while (!done && i < wk_n && wk_start[i] < e) begin
				ei = extent_end(wk_start[i], {16'd0, wk_len[i]});
				if (ei > e) begin
					sv = wk_src[i];
					p = wk_phys[i] + (e - wk_start[i]);
					wk_erase(i);
					wk_put(e, sv, p, ei - e);
					done = 1;
				end else
					wk_erase(i);
			end
		end
		if (wk_n >= WCAP) return 0;
		wk_put(off, s, phys, {16'd0, len});
		if (wk_n > DEPTH) return 0;
		for (int k = 0; k < wk_n; k++) begin
			tab_start[k] = wk_start[k];
			tab_len[k] = wk_len[k];
			tab_phys[k] = wk_phys[k];
			tab_src[k] = wk_src[k];
		end
		tab_n = wk_n;
		return 1;
	endfunction

	function automatic bit hole_marker(int i);
		return tab_len[i] == 0 && tab_phys[i] == OFS_ONES;
	endfunction

	// expected result of one accepted item
	function automatic res_t map_result(rec_t r);
		res_t x;
		int ub, k, m;
		bit stop;
		bit [47:0] ek;
		x.src = SRC_ONES;
		x.phys = OFS_ONES;
		x.run = 0;
		x.hole = 1;
		x.ovf = 0;
		if (r.mode == MODE_LOOKUP) begin
			ub = 0;
			while (ub < tab_n && tab_start[ub] <= r.offset) ub++;
			k = ub;
			stop = 0;
			while (k > 0 && !stop) begin
				k--;
				ek = extent_end(tab_start[k], {16'd0, tab_len[k]});
				if (ek <= r.offset)
					stop = 1;
				else if (!hole_marker(k)) begin
					x.src = tab_src[k];
					x.phys = tab_phys[k] + (r.offset - tab_start[k]);
					x.run = ek - r.offset;
					x.hole = 0;
					stop = 1;
				end
			end
			if (x.hole && ub < tab_n) begin
				m = ub;
				while (m < tab_n - 1 && hole_marker(m)) m++;
				x.run = tab_start[m] - r.offset;
			end
		end else begin
			x.ovf = !overlay_record(r.offset, r.length, r.phys,
				r.sid_ok ? r.sid : SRC_ONES);
			x.src = 0;
			x.phys = 0;
			x.run = 0;
			x.hole = 0;
		end
		x.size = (tab_n == 0) ? 48'd0
			: extent_end(tab_start[tab_n-1], {16'd0, tab_len[tab_n-1]});
		return x;
	endfunction

	function automatic logic [47:0] rand48();
		return {16'($urandom), $urandom};
	endfunction

	function automatic rec_t mk(logic m, logic [47:0] o, logic [31:0] l, logic [47:0] p,
			logic [15:0] s, logic sv);
		rec_t r;
		r.mode = m;
		r.offset = o;
		r.length = l;
		r.phys = p;
		r.sid = s;
		r.sid_ok = sv;
		r.drain = 0;
		return r;
	endfunction

	// random item; fill biases towards many small disjoint extents
	function automatic rec_t rand_rec(bit fill);
		int pick;
		pick = $urandom_range(99);
		if (fill && pick < 40)
			return mk(MODE_MERGE, 48'($urandom_range(255)) * 64, $urandom_range(1, 40),
				rand48(), 16'($urandom_range(65534)), 1'b1);
		if (pick < 45)
			return mk(MODE_MERGE, 48'($urandom_range(8191)), $urandom_range(1, 600),
				rand48(), 16'($urandom_range(65534)), $urandom_range(9) != 0);
		if (pick < 80)
			return mk(MODE_LOOKUP, 48'($urandom_range(17000)), $urandom, rand48(),
				16'($urandom), 1'($urandom_range(1)));
		if (pick < 83)
			return mk(MODE_MERGE, 48'($urandom_range(16383)), 0, OFS_ONES,
				16'($urandom_range(65534)), 1'($urandom_range(1)));
		if (pick < 92)
			return mk(MODE_MERGE, 48'($urandom_range(255)) * 64, $urandom_range(1, 40),
				rand48(), 16'($urandom_range(65534)), 1'b1);
		// noise across the full field ranges
		return mk(1'($urandom_range(1)), rand48(), $urandom, rand48(),
			16'($urandom_range(65534)), 1'($urandom_range(1)));
	endfunction

	// item driver, predicting at each accepted item
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			in_valid <= 1'b0;
			mode <= MODE_MERGE;
			logical_offset <= '0;
			record_length <= '0;
			src_offset <= '0;
			source_id <= '0;
			source_valid <= 1'b0;
		end else begin
			if (in_valid && !in_stall) begin
				rec_t cur;
				cur = mk(mode, logical_offset, record_length, src_offset, source_id,
					source_valid);
				if (mode == MODE_LOOKUP) n_lookup++; else n_merge++;
				result_q.insert(result_q.size(), map_result(cur));
			end
			if (!in_valid || !in_stall) begin
				if (rec_q.size() > 0 && !(rec_q[0].drain && result_q.size() > 0)
						&& $urandom_range(99) >= tx_idle_pct) begin
					rec_t r;
					r = rec_q[0];
					rec_q.delete(0);
					in_valid <= 1'b1;
					mode <= r.mode;
					logical_offset <= r.offset;
					record_length <= r.length;
					src_offset <= r.phys;
					source_id <= r.sid;
					source_valid <= r.sid_ok;
				end else
					in_valid <= 1'b0;
			end
		end
	end

	// result monitor and receiver stalls
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			out_stall <= 1'b0;
		else begin
			if (out_valid && !out_stall) begin
				if (result_q.size() == 0) begin
					$error("unexpected result, nothing outstanding");
					errors++;
				end else begin
					res_t x;
					x = result_q[0];
					result_q.delete(0);
					if (hit_source !== x.src) begin
						$error("hit_source exp %h got %h", x.src, hit_source); errors++;
					end
					if (hit_physical !== x.phys) begin
						$error("hit_physical exp %h got %h", x.phys, hit_physical); errors++;
					end
					if (run_length !== x.run) begin
						$error("run_length exp %h got %h", x.run, run_length); errors++;
					end
					if (is_hole !== x.hole) begin
						$error("is_hole exp %b got %b", x.hole, is_hole); errors++;
					end
					if (file_size !== x.size) begin
						$error("file_size exp %h got %h", x.size, file_size); errors++;
					end
					if (table_overflow !== x.ovf) begin
						$error("table_overflow exp %b got %b", x.ovf, table_overflow); errors++;
					end
					if (x.ovf) n_ovf++;
					if (x.hole) n_hole++;
				end
			end
			out_stall <= ($urandom_range(99) < rx_stall_pct);
		end
	end

	// watchdog on cycles with no item moving on either side
	always @(posedge clk) begin
		if (arst_n) begin
			if ((in_valid && !in_stall) || (out_valid && !out_stall))
				quiet_cycles <= 0;
			else if (quiet_cycles >= WDOG_LIMIT) begin
				$display("extent_overlay_map_top_tb: done, errors");
				$finish;
			end else
				quiet_cycles <= quiet_cycles + 1;
		end
	end

	initial begin
		rec_t r;
		// empty table, basic write, lookups inside, in a gap and past the end
		add_rec(mk(MODE_LOOKUP, 0, 0, 0, 0, 0));
		add_rec(mk(MODE_MERGE, 0, 100, 48'h1000, 16'd7, 1));
		add_rec(mk(MODE_LOOKUP, 50, 0, 0, 0, 0));
		add_rec(mk(MODE_MERGE, 200, 50, 48'h2000, 16'd9, 1));
		add_rec(mk(MODE_LOOKUP, 120, 0, 0, 0, 0));
		add_rec(mk(MODE_LOOKUP, 400, 0, 0, 0, 0));
		// split in the middle, same start replaces, hole source id
		add_rec(mk(MODE_MERGE, 20, 10, 48'h3000, 16'd3, 1));
		add_rec(mk(MODE_MERGE, 20, 5, 48'h4000, 16'd4, 0));
		add_rec(mk(MODE_LOOKUP, 22, 0, 0, 0, 0));
		add_rec(mk(MODE_LOOKUP, 27, 0, 0, 0, 0));
		// overlay covering several extents and trimming a tail
		add_rec(mk(MODE_MERGE, 10, 210, 48'h5000, 16'd65534, 1));
		// zero-length record that is not a truncate
		add_rec(mk(MODE_MERGE, 300, 0, 48'h10, 16'd1, 1));
		// truncate inside an extent, then lookups around the hole marker
		add_rec(mk(MODE_MERGE, 150, 0, OFS_ONES, 16'd0, 1));
		add_rec(mk(MODE_LOOKUP, 150, 0, 0, 0, 0));
		add_rec(mk(MODE_LOOKUP, 149, 0, 0, 0, 0));
		add_rec(mk(MODE_MERGE, 500, 20, 48'h0, 16'd2, 1));
		add_rec(mk(MODE_LOOKUP, 160, 0, 0, 0, 0));
		// saturating end and physical wrap at the top of the space
		add_rec(mk(MODE_MERGE, OFS_ONES - 10, 32'hFFFF_FFFF, OFS_ONES - 2, 16'd5, 1));
		add_rec(mk(MODE_LOOKUP, OFS_ONES - 1, 32'hFFFF_FFFF, OFS_ONES, 16'hFFFF, 1));
		add_rec(mk(MODE_LOOKUP, OFS_ONES, 0, 0, 0, 0));
		add_rec(mk(MODE_MERGE, 0, 0, OFS_ONES, 16'd0, 0));
		add_rec(mk(MODE_LOOKUP, 0, 0, 0, 0, 0));

		in_valid = 1'b0;
		out_stall = 1'b0;
		repeat (4) @(posedge clk);
		arst_n <= 1'b1;

		// idling phases: none, sender, receiver, both
		for (int ph = 0; ph < 4; ph++) begin
			while (rec_q.size() != 0) @(posedge clk);
			tx_idle_pct = (ph == 1) ? 60 : (ph == 3) ? 27 : 0;
			rx_stall_pct = (ph == 2) ? 60 : (ph == 3) ? 27 : 0;
			for (int n = 0; n < 310; n++) begin
				r = rand_rec(ph == 1 || ph == 3);
				// sender holds off until the block has drained
				r.drain = (n == 0 || n == 150);
				add_rec(r);
			end
		end
		while (rec_q.size() != 0 || result_q.size() != 0) @(posedge clk);
		repeat (300) @(posedge clk);
		$display("covered %0d merges (%0d overflowed) and %0d lookups (%0d holes)",
			n_merge, n_ovf, n_lookup, n_hole);
		$display("under no idling, sender gaps, receiver stalls and both together");
		if (errors == 0 && result_q.size() == 0)
			$display("extent_overlay_map_top_tb: done, clean");
		else
			$display("extent_overlay_map_top_tb: done, errors");
		$finish;
	end

endmodule

FILE: files.f
+incdir+rtl
rtl/eom_pkg.sv
rtl/eom_ctrl.sv
rtl/eom_dp.sv
rtl/extent_overlay_map_top.sv
bench/extent_overlay_map_top_tb.sv
